/* rtl/core/olst_pkg.sv */
`default_nettype none

package olst_pkg;

  // Field widths on the stream ports.
  localparam int REQ_FW      = 3;
  localparam int VAL_FW      = 32;
  localparam int IDX_FW      = 6;
  localparam int STS_FW      = 2;
  localparam int LEN_FW      = 7;
  localparam int IN_TDATA_W  = 40;
  localparam int IN_TUSER_W  = REQ_FW;
  localparam int OUT_TDATA_W = 48;

  // Request kinds.
  localparam logic [REQ_FW-1:0] REQ_PREPEND = 3'd0;
  localparam logic [REQ_FW-1:0] REQ_APPEND  = 3'd1;
  localparam logic [REQ_FW-1:0] REQ_TAKE    = 3'd2;
  localparam logic [REQ_FW-1:0] REQ_REM_IDX = 3'd3;
  localparam logic [REQ_FW-1:0] REQ_REM_VAL = 3'd4;
  localparam logic [REQ_FW-1:0] REQ_READ    = 3'd5;

  // Result status codes.
  localparam logic [STS_FW-1:0] ST_OK    = 2'd0;
  localparam logic [STS_FW-1:0] ST_FULL  = 2'd1;
  localparam logic [STS_FW-1:0] ST_MISS  = 2'd2;
  localparam logic [STS_FW-1:0] ST_EMPTY = 2'd3;

  // Datapath operations, one per cycle.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_SET_UP,
    OP_SET_HIT,
    OP_READ_IDX,
    OP_MOVE_UP,
    OP_MOVE_DN,
    OP_SCAN,
    OP_WR_HEAD,
    OP_WR_TAIL
  } op_t;

  typedef struct packed {
    op_t               op;
    logic              emit;
    logic [STS_FW-1:0] status;
    logic              with_data;
    logic              cnt_inc;
    logic              cnt_dec;
  } olst_cmd_t;

  typedef struct packed {
    logic [REQ_FW-1:0] req;
    logic              cnt_zero;
    logic              cnt_full;
    logic              idx_oob;
    logic              dn_more;
    logic              cur_zero;
    logic              scan_more;
    logic              scan_vld;
    logic              hit;
    logic              pend_vld;
    logic              slot_free;
  } olst_sts_t;

endpackage

`default_nettype wire

/* rtl/core/olst_ctrl.sv */
`default_nettype none

module olst_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire olst_pkg::olst_sts_t sts,
  output olst_pkg::olst_cmd_t cmd
);
  import olst_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_WAIT   = 3'd2;
  localparam logic [2:0] S_SHDN   = 3'd3;
  localparam logic [2:0] S_SHUP   = 3'd4;
  localparam logic [2:0] S_SCAN   = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [STS_FW-1:0] fst_r, fst_nxt;
  logic              fwd_r, fwd_nxt;
  logic              finc_r, finc_nxt;
  logic              fdec_r, fdec_nxt;

  always_comb begin
    state_nxt     = state_r;
    fst_nxt       = fst_r;
    fwd_nxt       = fwd_r;
    finc_nxt      = finc_r;
    fdec_nxt      = fdec_r;
    cmd           = '0;
    cmd.op        = OP_NOP;
    cmd.status    = fst_r;
    cmd.with_data = fwd_r;
    cmd.cnt_inc   = finc_r;
    cmd.cnt_dec   = fdec_r;
    in_ready      = (state_r == S_IDLE);

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        fst_nxt   = ST_OK;
        fwd_nxt   = 1'b0;
        finc_nxt  = 1'b0;
        fdec_nxt  = 1'b0;
        state_nxt = S_FINISH;
        unique case (sts.req)
          REQ_PREPEND: begin
            if (sts.cnt_full) begin
              fst_nxt = ST_FULL;
            end else begin
              cmd.op    = OP_SET_UP;
              state_nxt = S_SHUP;
            end
          end
          REQ_APPEND: begin
            if (sts.cnt_full) begin
              fst_nxt = ST_FULL;
            end else begin
              cmd.op   = OP_WR_TAIL;
              finc_nxt = 1'b1;
            end
          end
          REQ_TAKE, REQ_REM_IDX, REQ_READ: begin
            if (sts.cnt_zero) begin
              fst_nxt = ST_EMPTY;
            end else if (sts.idx_oob) begin
              fst_nxt = ST_MISS;
            end else begin
              cmd.op  = OP_READ_IDX;
              fwd_nxt = (sts.req != REQ_REM_IDX);
              if (sts.req == REQ_READ) begin
                state_nxt = S_WAIT;
              end else begin
                fdec_nxt  = 1'b1;
                state_nxt = S_SHDN;
              end
            end
          end
          REQ_REM_VAL: begin
            if (sts.cnt_zero) begin
              fst_nxt = ST_EMPTY;
            end else begin
              state_nxt = S_SCAN;
            end
          end
          default: begin
            fst_nxt = ST_OK;
          end
        endcase
      end
      S_WAIT: begin
        state_nxt = S_FINISH;
      end
      S_SHDN: begin
        if (sts.dn_more) begin
          cmd.op = OP_MOVE_DN;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_SHUP: begin
        if (!sts.cur_zero) begin
          cmd.op = OP_MOVE_UP;
        end else if (!sts.pend_vld) begin
          cmd.op    = OP_WR_HEAD;
          finc_nxt  = 1'b1;
          state_nxt = S_FINISH;
        end
      end
      S_SCAN: begin
        priority if (sts.hit) begin
          cmd.op    = OP_SET_HIT;
          fdec_nxt  = 1'b1;
          state_nxt = S_SHDN;
        end else if (sts.scan_more) begin
          cmd.op = OP_SCAN;
        end else if (!sts.scan_vld) begin
          fst_nxt   = ST_MISS;
          state_nxt = S_FINISH;
        end else begin
          // The last compare missed; wait for its valid to drop.
          state_nxt = S_SCAN;
        end
      end
      S_FINISH: begin
        cmd.emit = sts.slot_free;
        if (sts.slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fst_r   <= ST_OK;
      fwd_r   <= 1'b0;
      finc_r  <= 1'b0;
      fdec_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fst_r   <= fst_nxt;
      fwd_r   <= fwd_nxt;
      finc_r  <= finc_nxt;
      fdec_r  <= fdec_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/olst_dp.sv */
`default_nettype none

module olst_dp #(
  parameter int DEPTH       = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire  [olst_pkg::REQ_FW-1:0]  in_req,
  input  wire  [olst_pkg::VAL_FW-1:0]  in_value,
  input  wire  [olst_pkg::IDX_FW-1:0]  in_index,
  input  wire olst_pkg::olst_cmd_t     cmd,
  output olst_pkg::olst_sts_t          sts,
  input  wire                          out_ready,
  output logic                         out_valid,
  output logic [olst_pkg::STS_FW-1:0]  out_status,
  output logic [olst_pkg::VAL_FW-1:0]  out_data,
  output logic [olst_pkg::LEN_FW-1:0]  out_length,
  output logic                         out_empty
);
  import olst_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > IDX_FW) ? CW : IDX_FW;
  localparam int LW = (CW > LEN_FW) ? CW : LEN_FW;
  localparam int DW = (VALUE_WIDTH < VAL_FW) ? VALUE_WIDTH : VAL_FW;

  logic [VALUE_WIDTH-1:0] mem_r [DEPTH];
  logic [VALUE_WIDTH-1:0] rd_r;

  logic [REQ_FW-1:0]      req_r, req_nxt;
  logic [VALUE_WIDTH-1:0] val_r, val_nxt;
  logic [IDX_FW-1:0]      idx_r, idx_nxt;
  logic [VALUE_WIDTH-1:0] data_r, data_nxt;
  logic [CW-1:0]          cur_r, cur_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic                   rdi_r, rdi_nxt;
  logic                   scan_vld_r, scan_vld_nxt;
  logic [AW-1:0]          scan_pos_r, scan_pos_nxt;
  logic                   pend_vld_r, pend_vld_nxt;
  logic [AW-1:0]          pend_addr_r, pend_addr_nxt;
  logic                   out_vld_r, out_vld_nxt;
  logic [STS_FW-1:0]      o_status_r, o_status_nxt;
  logic [VAL_FW-1:0]      o_data_r, o_data_nxt;
  logic [LEN_FW-1:0]      o_len_r, o_len_nxt;
  logic                   o_empty_r, o_empty_nxt;

  logic [VALUE_WIDTH-1:0] val_in;
  logic [VAL_FW-1:0]      data_w;
  logic [XW-1:0]          idx_x;
  logic [CW:0]            cur_p1;
  logic [AW-1:0]          cur_a;
  logic [AW-1:0]          cur_m1;
  logic                   re;
  logic [AW-1:0]          raddr;
  logic                   we;
  logic [AW-1:0]          waddr;
  logic [VALUE_WIDTH-1:0] wdata;

  // Incoming value is cut to the port width and the stored width.
  always_comb begin
    val_in         = '0;
    val_in[DW-1:0] = in_value[DW-1:0];
    data_w         = '0;
    data_w[DW-1:0] = data_r[DW-1:0];
  end

  assign idx_x  = XW'(idx_r);
  assign cur_p1 = {1'b0, cur_r} + (CW + 1)'(1);
  assign cur_a  = cur_r[AW-1:0];
  assign cur_m1 = cur_a - AW'(1);

  always_comb begin
    sts.req       = req_r;
    sts.cnt_zero  = (cnt_r == '0);
    sts.cnt_full  = (cnt_r == CW'(DEPTH));
    sts.idx_oob   = (idx_x >= XW'(cnt_r));
    sts.dn_more   = (cur_p1 < {1'b0, cnt_r});
    sts.cur_zero  = (cur_r == '0);
    sts.scan_more = (cur_r < cnt_r);
    sts.scan_vld  = scan_vld_r;
    sts.hit       = scan_vld_r && (rd_r == val_r);
    sts.pend_vld  = pend_vld_r;
    sts.slot_free = !out_vld_r || out_ready;
  end

  // Read port select.
  always_comb begin
    re    = 1'b0;
    raddr = cur_a;
    unique case (cmd.op)
      OP_READ_IDX: begin
        re    = 1'b1;
        raddr = AW'(idx_x);
      end
      OP_MOVE_UP: begin
        re    = 1'b1;
        raddr = cur_m1;
      end
      OP_MOVE_DN: begin
        re    = 1'b1;
        raddr = cur_p1[AW-1:0];
      end
      OP_SCAN: begin
        re    = 1'b1;
        raddr = cur_a;
      end
      default: begin
        re = 1'b0;
      end
    endcase
  end

  // Write port select; the pending move write has the port to itself.
  always_comb begin
    we    = 1'b0;
    waddr = pend_addr_r;
    wdata = rd_r;
    priority if (pend_vld_r) begin
      we = 1'b1;
    end else if (cmd.op == OP_WR_HEAD) begin
      we    = 1'b1;
      waddr = '0;
      wdata = val_r;
    end else if (cmd.op == OP_WR_TAIL) begin
      we    = 1'b1;
      waddr = cnt_r[AW-1:0];
      wdata = val_r;
    end else begin
      we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rd_r <= mem_r[raddr];
    end
  end

  always_comb begin
    req_nxt       = req_r;
    val_nxt       = val_r;
    idx_nxt       = idx_r;
    data_nxt      = rdi_r ? rd_r : data_r;
    cur_nxt       = cur_r;
    cnt_nxt       = cnt_r;
    rdi_nxt       = (cmd.op == OP_READ_IDX);
    scan_vld_nxt  = (cmd.op == OP_SCAN);
    scan_pos_nxt  = cur_a;
    pend_vld_nxt  = (cmd.op == OP_MOVE_UP) || (cmd.op == OP_MOVE_DN);
    pend_addr_nxt = cur_a;
    out_vld_nxt   = out_vld_r && !out_ready;
    o_status_nxt  = o_status_r;
    o_data_nxt    = o_data_r;
    o_len_nxt     = o_len_r;
    o_empty_nxt   = o_empty_r;

    unique case (cmd.op)
      OP_LOAD: begin
        req_nxt = in_req;
        val_nxt = val_in;
        idx_nxt = (in_req == REQ_TAKE) ? '0 : in_index;
        cur_nxt = '0;
      end
      OP_SET_UP:   cur_nxt = cnt_r;
      OP_SET_HIT:  cur_nxt = CW'(scan_pos_r);
      OP_READ_IDX: cur_nxt = CW'(idx_x);
      OP_MOVE_UP:  cur_nxt = cur_r - CW'(1);
      OP_MOVE_DN:  cur_nxt = cur_p1[CW-1:0];
      OP_SCAN:     cur_nxt = cur_p1[CW-1:0];
      default:     cur_nxt = cur_r;
    endcase

    if (cmd.emit) begin
      if (cmd.cnt_inc) begin
        cnt_nxt = cnt_r + CW'(1);
      end else if (cmd.cnt_dec) begin
        cnt_nxt = cnt_r - CW'(1);
      end
      out_vld_nxt  = 1'b1;
      o_status_nxt = cmd.status;
      o_data_nxt   = (cmd.with_data && cmd.status == ST_OK) ? data_w : '0;
      o_len_nxt    = LEN_FW'(LW'(cnt_nxt));
      o_empty_nxt  = (cnt_nxt == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      cur_r      <= '0;
      rdi_r      <= 1'b0;
      scan_vld_r <= 1'b0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      cnt_r      <= cnt_nxt;
      cur_r      <= cur_nxt;
      rdi_r      <= rdi_nxt;
      scan_vld_r <= scan_vld_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    val_r       <= val_nxt;
    idx_r       <= idx_nxt;
    data_r      <= data_nxt;
    scan_pos_r  <= scan_pos_nxt;
    pend_addr_r <= pend_addr_nxt;
    o_status_r  <= o_status_nxt;
    o_data_r    <= o_data_nxt;
    o_len_r     <= o_len_nxt;
    o_empty_r   <= o_empty_nxt;
  end

  assign out_valid  = out_vld_r;
  assign out_status = o_status_r;
  assign out_data   = o_data_r;
  assign out_length = o_len_r;
  assign out_empty  = o_empty_r;

endmodule

`default_nettype wire

/* rtl/core/ordered_list_store.sv */
// From the accepting edge to a valid result: append, rejected requests and unused codes
// go from decode to finish, a read passes the wait state, a prepend shifts the entries up
// from the tail and writes the head, a removal at position p shifts the entries behind p
// down, and a removal by value scans from the head to a hit or the end, then shifts down.
// One word is taken at a time; the shift or scan moves one entry per cycle through the two-port memory.
// Reset (rst_n low, synchronous) empties the list; the entry memory itself is not cleared.
`default_nettype none

module ordered_list_store #(
  parameter int DEPTH       = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_tvalid,
  output logic                               in_tready,
  // value [31:0], index [37:32], zero [39:38]
  input  wire  [olst_pkg::IN_TDATA_W-1:0]    in_tdata,
  // req_type [2:0]
  input  wire  [olst_pkg::IN_TUSER_W-1:0]    in_tuser,
  output logic                               out_tvalid,
  input  wire                                out_tready,
  // status [1:0], data_out [33:2], length [40:34], empty [41], zero [47:42]
  output logic [olst_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import olst_pkg::*;

  // The controller walks each request through decode, an optional shift or scan of the
  // entry memory, and a finish step that loads the result register. The datapath holds
  // the memory, the entry count, the walking cursor and the result register. A new word
  // is taken as soon as the controller is back in idle, even while the previous result
  // still waits in the output register.

  olst_cmd_t         cmd;
  olst_sts_t         sts;
  logic [STS_FW-1:0] res_status;
  logic [VAL_FW-1:0] res_data;
  logic [LEN_FW-1:0] res_length;
  logic              res_empty;

  olst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  olst_dp #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_req     (in_tuser),
    .in_value   (in_tdata[VAL_FW-1:0]),
    .in_index   (in_tdata[VAL_FW+IDX_FW-1:VAL_FW]),
    .cmd        (cmd),
    .sts        (sts),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_status (res_status),
    .out_data   (res_data),
    .out_length (res_length),
    .out_empty  (res_empty)
  );

  assign out_tdata = {
    (OUT_TDATA_W - STS_FW - VAL_FW - LEN_FW - 1)'(0),
    res_empty, res_length, res_data, res_status
  };

  // A result is only loaded when the output register is free or being drained.
  a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.slot_free)
    else $error("result loaded over a waiting word");

  // A pending shift write and a value write never share the write port.
  a_wr_port: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_WR_HEAD || cmd.op == OP_WR_TAIL) |-> !sts.pend_vld)
    else $error("write port conflict");

  // Nothing of a finished request is still in flight when a new word can be taken.
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (!sts.pend_vld && !sts.scan_vld))
    else $error("shift or scan still in flight at idle");

  // The count only moves on a successful request and never grows past the depth.
  a_cnt_move: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && (cmd.cnt_inc || cmd.cnt_dec)) |->
      (cmd.status == ST_OK && !(cmd.cnt_inc && sts.cnt_full)))
    else $error("count change on a failed request or past depth");

endmodule

`default_nettype wire

/* tb/sv/ordered_list_checker.sv */
module ordered_list_checker
  import olst_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_tvalid,
  input  wire                    in_tready,
  input  wire [IN_TDATA_W-1:0]   in_tdata,
  input  wire [IN_TUSER_W-1:0]   in_tuser,
  input  wire                    out_tvalid,
  input  wire                    out_tready,
  input  wire [OUT_TDATA_W-1:0]  out_tdata,
  output int                     mismatches,
  output int                     awaiting,
  output int                     held_count,
  output int                     results_checked,
  output int                     full_rejects,
  output int                     empty_hits
);

  typedef struct packed {
    logic [STS_FW-1:0] status;
    logic [VAL_FW-1:0] data;
    logic [LEN_FW-1:0] length;
    logic              empty;
  } list_result_t;

  logic [VAL_FW-1:0] shadow_list [DEPTH];
  list_result_t      pending_results [$];

  // Drops the entry at pos and shifts the tail down by one.
  function automatic void drop_at(int pos);
    for (int i = pos; i + 1 < held_count; i++) shadow_list[i] = shadow_list[i + 1];
    held_count--;
  endfunction

  function automatic list_result_t apply_request(logic [REQ_FW-1:0] req,
                                                  logic [VAL_FW-1:0] val,
                                                  logic [IDX_FW-1:0] idx);
    list_result_t r;
    int hit_pos;
    r.status = ST_OK;
    r.data   = '0;
    hit_pos  = -1;
    case (req)
      REQ_PREPEND, REQ_APPEND: begin
        if (held_count >= DEPTH) begin
          r.status = ST_FULL;
        end else if (req == REQ_PREPEND) begin
          for (int i = held_count; i > 0; i--) shadow_list[i] = shadow_list[i - 1];
          shadow_list[0] = val;
          held_count++;
        end else begin
          shadow_list[held_count] = val;
          held_count++;
        end
      end
      REQ_TAKE: begin
        if (held_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.data = shadow_list[0];
          drop_at(0);
        end
      end
      REQ_REM_IDX: begin
        if (held_count == 0) r.status = ST_EMPTY;
        else if (idx >= held_count) r.status = ST_MISS;
        else drop_at(idx);
      end
      REQ_REM_VAL: begin
        if (held_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          for (int i = 0; i < held_count; i++) begin
            if (hit_pos < 0 && shadow_list[i] == val) hit_pos = i;
          end
          if (hit_pos < 0) r.status = ST_MISS;
          else drop_at(hit_pos);
        end
      end
      REQ_READ: begin
        if (held_count == 0) r.status = ST_EMPTY;
        else if (idx >= held_count) r.status = ST_MISS;
        else r.data = shadow_list[idx];
      end
      default: ;
    endcase
    r.length = LEN_FW'(held_count);
    r.empty  = (held_count == 0);
    return r;
  endfunction

  always @(posedge clk) begin
    list_result_t want;
    list_result_t got;
    if (!rst_n) begin
      held_count = 0;
      pending_results.delete();
      mismatches = 0;
      results_checked = 0;
      full_rejects = 0;
      empty_hits = 0;
    end else begin
      // The result side is handled first so that a word accepted on this edge
      // can never be matched against a request accepted on the same edge.
      if (out_tvalid && out_tready) begin
        got.status = out_tdata[1:0];
        got.data   = out_tdata[33:2];
        got.length = out_tdata[40:34];
        got.empty  = out_tdata[41];
        if (pending_results.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result word with nothing expected: status %0d data %h length %0d",
                     $realtime, got.status, got.data, got.length);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          if (want.status == ST_FULL) full_rejects++;
          if (want.status == ST_EMPTY) empty_hits++;
          if (got.status != want.status || got.data != want.data ||
              got.length != want.length || got.empty != want.empty) begin
            if (mismatches < 10)
              $display("%0t: result %0d wrong: status %0d/%0d data %h/%h length %0d/%0d empty %0b/%0b (exp/got)",
                       $realtime, results_checked, want.status, got.status, want.data,
                       got.data, want.length, got.length, want.empty, got.empty);
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready)
        pending_results.push_back(apply_request(in_tuser, in_tdata[31:0], in_tdata[37:32]));
    end
    awaiting = pending_results.size();
  end

endmodule

/* tb/sv/ordered_list_store_tb.sv */
module ordered_list_store_tb;
  import olst_pkg::*;

  // The two request codes the block does not use; it must answer them with a plain ok.
  localparam logic [REQ_FW-1:0] REQ_SPARE_A = 3'd6;
  localparam logic [REQ_FW-1:0] REQ_SPARE_B = 3'd7;

  localparam int LIST_DEPTH = 64;
  localparam int PHASE_WORDS = 63;
  localparam int HOLD_CYCLES = 400;

  // Phase kinds of the random part; each one biases how often entries are inserted.
  typedef enum int {MIX, GROW, FILL, SHRINK} phase_kind_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [IN_TUSER_W-1:0]  in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int mismatches;
  int awaiting;
  int held_count;
  int results_checked;
  int full_rejects;
  int empty_hits;

  int          send_idle_pct;
  int          recv_idle_pct;
  bit          stall_request;
  int          hold_left;
  int          words_sent;
  logic [31:0] value_pool [8];

  ordered_list_store #(
    .DEPTH      (LIST_DEPTH),
    .VALUE_WIDTH(VAL_FW)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  ordered_list_checker #(
    .DEPTH(LIST_DEPTH)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .mismatches     (mismatches),
    .awaiting       (awaiting),
    .held_count     (held_count),
    .results_checked(results_checked),
    .full_rejects   (full_rejects),
    .empty_hits     (empty_hits)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Safety net: even the slowest legal run is far shorter than this.
  initial begin
    #12_000_000;
    $display("ordered_list_store_tb: done, errors");
    $finish;
  end

  // Result side. Each falling edge decides whether the next rising edge takes a word.
  // A hold-off asked for by the stimulus process is counted down here, cycle by cycle,
  // so the block backs up and must stall its input while the sender keeps offering.
  initial begin
    out_tready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (stall_request) begin
        stall_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else begin
        out_tready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offers one request word, starting at a falling edge, and returns at the falling edge
  // after the handshake. The valid is left high so back-to-back words need no gap; the
  // idle loop of the next call lowers it when a gap is wanted.
  task automatic send_word(input logic [REQ_FW-1:0] req, input logic [VAL_FW-1:0] val,
                           input logic [IDX_FW-1:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = req;
    in_tdata  = {2'b00, idx, val};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  // Holds the input quiet until every outstanding result has been taken or the cycle limit runs out.
  task automatic wait_for_drain(input int limit_cycles);
    int waited;
    waited = 0;
    in_tvalid = 1'b0;
    while (awaiting != 0 && waited < limit_cycles) begin
      @(negedge clk);
      waited++;
    end
  endtask

  // Half the values come from a small pool so that removal by value finds matches and
  // duplicates appear; the rest are fully random so every data bit toggles.
  function automatic logic [VAL_FW-1:0] pick_value();
    if ($urandom_range(1) == 0) return value_pool[$urandom_range(7)];
    return $urandom;
  endfunction

  // Mostly indexes that land inside the list, sometimes any index at all.
  function automatic logic [IDX_FW-1:0] pick_index();
    if (held_count > 0 && $urandom_range(99) < 75)
      return IDX_FW'($urandom_range(held_count - 1));
    return IDX_FW'($urandom_range(63));
  endfunction

  task automatic run_phase(input phase_kind_t kind, input int words);
    int insert_pct;
    int roll;
    logic [REQ_FW-1:0] req;
    case (kind)
      GROW:    insert_pct = 80;
      FILL:    insert_pct = 97;
      SHRINK:  insert_pct = 15;
      default: insert_pct = 45;
    endcase
    repeat (words) begin
      roll = $urandom_range(99);
      if (roll < 3) begin
        req = ($urandom_range(1) == 0) ? REQ_SPARE_A : REQ_SPARE_B;
      end else if (roll < 3 + insert_pct) begin
        req = ($urandom_range(1) == 0) ? REQ_PREPEND : REQ_APPEND;
      end else begin
        case ($urandom_range(3))
          0:       req = REQ_TAKE;
          1:       req = REQ_REM_IDX;
          2:       req = REQ_REM_VAL;
          default: req = REQ_READ;
        endcase
      end
      send_word(req, pick_value(), pick_index());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = REQ_PREPEND;
    stall_request = 1'b0;
    send_idle_pct = 36;
    recv_idle_pct = 36;
    words_sent = 0;
    value_pool[0] = 32'h0000_0000;
    value_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 8; i++) value_pool[i] = $urandom;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed part. Every removal and read on the empty list first, then the unused
    // codes, a short list with both extreme values and a duplicate, reads and removals
    // in and out of range, a value search that misses, one that must remove only the
    // first of two equal entries, and finally emptying the list again.
    send_word(REQ_TAKE,    32'h0,         6'd0);
    send_word(REQ_REM_IDX, 32'h0,         6'd0);
    send_word(REQ_REM_VAL, 32'h0,         6'd0);
    send_word(REQ_READ,    32'h0,         6'd63);
    send_word(REQ_SPARE_A, 32'hFFFF_FFFF, 6'd63);
    send_word(REQ_SPARE_B, 32'h0,         6'd0);
    send_word(REQ_APPEND,  32'hFFFF_FFFF, 6'd63);
    send_word(REQ_PREPEND, 32'h0,         6'd0);
    send_word(REQ_APPEND,  32'hA5A5_A5A5, 6'd21);
    send_word(REQ_APPEND,  32'h0,         6'd42);
    send_word(REQ_READ,    32'h0,         6'd0);
    send_word(REQ_READ,    32'h0,         6'd3);
    send_word(REQ_READ,    32'h0,         6'd4);
    send_word(REQ_READ,    32'h0,         6'd63);
    send_word(REQ_REM_VAL, 32'h1234_5678, 6'd0);
    send_word(REQ_REM_VAL, 32'h0,         6'd0);
    send_word(REQ_READ,    32'h0,         6'd2);
    send_word(REQ_REM_IDX, 32'h0,         6'd63);
    send_word(REQ_REM_IDX, 32'h0,         6'd1);
    send_word(REQ_TAKE,    32'h0,         6'd0);
    send_word(REQ_TAKE,    32'h0,         6'd0);
    send_word(REQ_TAKE,    32'h0,         6'd0);

    // Random part. Growing and filling phases push the list against its capacity so
    // inserts get rejected; shrinking phases drain it so the empty answers come back.
    run_phase(GROW, PHASE_WORDS);
    run_phase(FILL, PHASE_WORDS);

    // Long receiver hold-off while the sender offers words without gaps.
    send_idle_pct = 0;
    stall_request = 1'b1;
    run_phase(MIX, PHASE_WORDS);
    send_idle_pct = 36;

    run_phase(SHRINK, PHASE_WORDS);
    run_phase(SHRINK, PHASE_WORDS);

    // The sender goes quiet until every outstanding result is back.
    wait_for_drain(20_000);

    run_phase(GROW, PHASE_WORDS);
    run_phase(FILL, PHASE_WORDS);

    // A stretch with no idling on either side.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(MIX, PHASE_WORDS);
    send_idle_pct = 36;
    recv_idle_pct = 36;

    run_phase(SHRINK, PHASE_WORDS);
    run_phase(MIX, PHASE_WORDS);

    // Let the last results out, then give a possible stray word time to show up.
    wait_for_drain(20_000);
    repeat (150) @(negedge clk);

    $display("ordered_list_store_tb: %0d request words sent, %0d result words checked",
             words_sent, results_checked);
    $display("ordered_list_store_tb: %0d inserts rejected on a full list, %0d empty-list answers",
             full_rejects, empty_hits);
    if (mismatches == 0 && awaiting == 0) begin
      $display("ordered_list_store_tb: done, clean");
    end else begin
      $display("ordered_list_store_tb: %0d mismatches, %0d results never arrived",
               mismatches, awaiting);
      $display("ordered_list_store_tb: done, errors");
    end
    $finish;
  end

endmodule
